/* rtl/p2f_pkg.sv */
// ----------------------------------------------------------------------------
// p2f_pkg
// types and constants of the square-wave to fm register write translator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p2f_pkg;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LD_LO  = 8'b0000_0010,
        ST_LD_HI  = 8'b0000_0100,
        ST_DIV    = 8'b0000_1000,
        ST_NORM   = 8'b0001_0000,
        ST_TONE   = 8'b0010_0000,
        ST_LVL_RD = 8'b0100_0000,
        ST_LVL    = 8'b1000_0000
    } p2f_state_t;

    // arithmetic
    localparam int          QUO_W      = 22;
    localparam int          PER_W      = 12;
    localparam int          BLK_W      = 4;
    localparam logic [QUO_W-1:0] DIVIDEND   = 22'd2345678;
    localparam logic [QUO_W-1:0] FREQ_LIMIT = 22'd1024;
    localparam logic [4:0]  DIV_LAST   = 5'd21;

    // sound chip register numbers
    localparam logic [3:0]  PSG_TONE_LAST = 4'd5;
    localparam logic [3:0]  PSG_MIXER     = 4'd7;
    localparam logic [3:0]  PSG_AMP_A     = 4'd8;
    localparam logic [3:0]  PSG_AMP_C     = 4'd10;
    localparam logic [3:0]  LVL_ENVELOPE  = 4'd12;

    // fm register addresses
    localparam logic [7:0]  FM_FNUM_LO       = 8'hA0;
    localparam logic [7:0]  FM_BLOCK         = 8'hB0;
    localparam logic [7:0]  FM_NOISE_FNUM_LO = 8'hA7;
    localparam logic [7:0]  FM_NOISE_BLOCK   = 8'hB7;
    localparam logic [7:0]  FM_LEVEL         = 8'h43;
    localparam logic [7:0]  FM_NOISE_LEVEL   = 8'h54;
    localparam logic [7:0]  FM_KEY_ON        = 8'h20;

    // configuration port
    localparam int          APB_ADDR_W      = 3;
    localparam int          APB_DATA_W      = 32;
    localparam int          CFG_SEL_BIT     = 2;
    localparam logic        CFG_TRANSLATE   = 1'b0;
    localparam logic        CFG_NOISE_LEVEL = 1'b1;

    // amplitude to fm attenuation
    function automatic logic [7:0] p2f_level(input logic [3:0] idx);
        logic [7:0] lvl;
        unique case (idx)
            4'd0:    lvl = 8'hFF;
            4'd1:    lvl = 8'h3F;
            4'd2:    lvl = 8'h3F;
            4'd3:    lvl = 8'h3F;
            4'd4:    lvl = 8'h2C;
            4'd5:    lvl = 8'h26;
            4'd6:    lvl = 8'h22;
            4'd7:    lvl = 8'h1D;
            4'd8:    lvl = 8'h16;
            4'd9:    lvl = 8'h12;
            4'd10:   lvl = 8'h0C;
            4'd11:   lvl = 8'h0A;
            4'd12:   lvl = 8'h07;
            4'd13:   lvl = 8'h05;
            4'd14:   lvl = 8'h02;
            default: lvl = 8'h00;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

/* rtl/psg_to_fm_register_translator.sv */
// ----------------------------------------------------------------------------
// psg_to_fm_register_translator
// stores square-wave chip register writes and issues matching fm writes
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  contents
//  s_*       in   s_tvalid / s_tready        tdata: reg_index, reg_value
//  m_*       out  m_tvalid / m_tready        tdata: fm_reg, fm_value; tlast
//  apb       in   psel & penable & pwrite    translate_enable @0, noise_level_enable @4
//
//  tone write: accept, 2 load, 22 restoring divide (one quotient bit per cycle), up to 13
//  normalize (one shift per cycle, then the final compare), 4 emit slots
//  level write: accept, then per voice an amplitude read and two emit slots (all three
//  voices on a mixer write); ignored or plain stores leave the sequencer idle, and
//  s_tready is low while it runs; a stalled m_tready holds the sequencer at its emit slot
//  reset clears the register store, sequencer and output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psg_to_fm_register_translator
    import p2f_pkg::*;
#(
    parameter int REG_COUNT = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [3:0] reg_index, [11:4] reg_value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,   // [7:0] fm_reg, [15:8] fm_value
    output logic                       m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam int CNT_W = $clog2(REG_COUNT + 1);

    p2f_state_t         state_reg, state_next;
    logic [1:0]         voice_reg, voice_next;
    logic               multi_reg, multi_next;
    logic [PER_W-1:0]   div_reg, div_next;
    logic [PER_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic [1:0]         slot_reg, slot_next;
    logic [3:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_reg_reg, out_reg_next;
    logic [7:0]         out_val_reg, out_val_next;
    logic               out_last_reg, out_last_next;
    logic               translate_enable_reg;
    logic               noise_level_enable_reg;

    logic [7:0]         sound_regs_reg [REG_COUNT];

    logic [3:0]         reg_index;
    logic [7:0]         reg_value;
    logic               in_accept;
    logic               in_range;
    logic               cfg_write;
    logic [3:0]         rd_addr;
    logic [7:0]         rd_data;
    logic [7:0]         mix;
    logic               out_free;
    logic [13:0]        trial;
    logic               trial_ge;
    logic [PER_W-1:0]   period;
    logic [3:0]         tone_en;
    logic [3:0]         tone_later;
    logic [7:0]         tone_lo;
    logic [7:0]         tone_hi;
    logic               voice_muted;
    logic               noise_off;
    logic               noise_en;
    logic               last_voice;

    assign reg_index = s_tdata[3:0];
    assign reg_value = s_tdata[11:4];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = CNT_W'(reg_index) < CNT_W'(REG_COUNT);

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_val_reg, out_reg_reg};
    assign m_tlast   = out_last_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[CFG_SEL_BIT] == CFG_NOISE_LEVEL)
        begin
            prdata[0] = noise_level_enable_reg;
        end
        else
        begin
            prdata[0] = translate_enable_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            translate_enable_reg   <= 1'b1;
            noise_level_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (paddr[CFG_SEL_BIT] == CFG_NOISE_LEVEL)
            begin
                noise_level_enable_reg <= pwdata[0];
            end
            else
            begin
                translate_enable_reg <= pwdata[0];
            end
        end
    end

    // register store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                sound_regs_reg[i] <= '0;
            end
        end
        else if (in_accept && in_range)
        begin
            sound_regs_reg[reg_index[IDX_W-1:0]] <= reg_value;
        end
    end

    // read port, address picked by the sequencer; the mixer register has its own read
    always_comb
    begin
        unique case (state_reg)
            ST_LD_LO: rd_addr = {1'b0, voice_reg, 1'b0};
            ST_LD_HI: rd_addr = {1'b0, voice_reg, 1'b1};
            default:  rd_addr = PSG_AMP_A + {2'b00, voice_reg};
        endcase
    end

    assign rd_data = sound_regs_reg[rd_addr[IDX_W-1:0]];
    assign mix     = sound_regs_reg[PSG_MIXER];

    // shared restoring divide step
    assign trial    = {1'b0, rem_reg, quo_reg[QUO_W-1]} - {2'b00, div_reg};
    assign trial_ge = !trial[13];
    assign period   = {rd_data[3:0], div_reg[7:0]};

    // tone emit slots: voice lo, voice hi, noise lo, noise hi
    assign tone_en[0]  = !mix[voice_reg];
    assign tone_en[1]  = !mix[voice_reg];
    assign tone_en[2]  = !mix[{1'b0, voice_reg} + 3'd3];
    assign tone_en[3]  = !mix[{1'b0, voice_reg} + 3'd3];
    assign tone_later  = tone_en >> ({1'b0, slot_reg} + 3'd1);
    assign tone_lo     = quo_reg[7:0];
    assign tone_hi     = {2'b00, blk_reg, quo_reg[9:8]} | FM_KEY_ON;

    // level emit slots: voice level, noise level
    assign voice_muted = mix[voice_reg];
    assign noise_off   = (mix[5:3] == 3'b111);
    assign noise_en    = noise_off || noise_level_enable_reg;
    assign last_voice  = !multi_reg || (voice_reg == 2'd2);

    always_comb
    begin
        state_next     = state_reg;
        voice_next     = voice_reg;
        multi_next     = multi_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        blk_next       = blk_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_reg_next   = out_reg_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_range && translate_enable_reg)
                begin
                    priority if (reg_index <= PSG_TONE_LAST)
                    begin
                        voice_next = reg_index[2:1];
                        state_next = ST_LD_LO;
                    end
                    else if (reg_index == PSG_MIXER)
                    begin
                        voice_next = 2'd0;
                        multi_next = 1'b1;
                        state_next = ST_LVL_RD;
                    end
                    else if (reg_index >= PSG_AMP_A && reg_index <= PSG_AMP_C)
                    begin
                        voice_next = 2'(reg_index - PSG_AMP_A);
                        multi_next = 1'b0;
                        state_next = ST_LVL_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_LD_LO:
            begin
                div_next[7:0] = rd_data;
                state_next    = ST_LD_HI;
            end

            ST_LD_HI:
            begin
                div_next = period;
                rem_next = '0;
                cnt_next = '0;
                blk_next = '0;
                if (period == '0)
                begin
                    quo_next   = QUO_W'(1);
                    state_next = ST_NORM;
                end
                else
                begin
                    quo_next   = DIVIDEND;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = trial_ge ? trial[PER_W-1:0] : {rem_reg[PER_W-2:0], quo_reg[QUO_W-1]};
                quo_next = {quo_reg[QUO_W-2:0], trial_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_NORM;
                end
            end

            ST_NORM:
            begin
                if (quo_reg > FREQ_LIMIT)
                begin
                    quo_next = quo_reg >> 1;
                    blk_next = blk_reg + BLK_W'(1);
                end
                else
                begin
                    slot_next  = 2'd0;
                    state_next = ST_TONE;
                end
            end

            ST_TONE:
            begin
                if (out_free)
                begin
                    if (tone_en[slot_reg])
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = (tone_later == 4'd0);
                        unique case (slot_reg)
                            2'd0:
                            begin
                                out_reg_next = FM_FNUM_LO + {6'd0, voice_reg};
                                out_val_next = tone_lo;
                            end
                            2'd1:
                            begin
                                out_reg_next = FM_BLOCK + {6'd0, voice_reg};
                                out_val_next = tone_hi;
                            end
                            2'd2:
                            begin
                                out_reg_next = FM_NOISE_FNUM_LO;
                                out_val_next = tone_lo;
                            end
                            default:
                            begin
                                out_reg_next = FM_NOISE_BLOCK;
                                out_val_next = tone_hi;
                            end
                        endcase
                    end
                    slot_next = slot_reg + 2'd1;
                    if (slot_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_LVL_RD:
            begin
                idx_next   = rd_data[4] ? LVL_ENVELOPE : rd_data[3:0];
                slot_next  = 2'd0;
                state_next = ST_LVL;
            end

            default:
            begin
                // ST_LVL
                if (out_free)
                begin
                    if (slot_reg == 2'd0)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = last_voice && !noise_en;
                        out_reg_next   = FM_LEVEL + {6'd0, voice_reg};
                        out_val_next   = p2f_level(voice_muted ? 4'd0 : idx_reg);
                        slot_next      = 2'd1;
                    end
                    else
                    begin
                        if (noise_en)
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = last_voice;
                            out_reg_next   = FM_NOISE_LEVEL;
                            out_val_next   = p2f_level(noise_off ? 4'd0 : idx_reg);
                        end
                        if (last_voice)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            voice_next = voice_reg + 2'd1;
                            state_next = ST_LVL_RD;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            voice_reg     <= '0;
            multi_reg     <= 1'b0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            voice_reg     <= voice_next;
            multi_reg     <= multi_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        blk_reg      <= blk_next;
        idx_reg      <= idx_next;
        out_reg_reg  <= out_reg_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

/* rtl/p2f_checker.sv */
// ----------------------------------------------------------------------------
// p2f_checker
// port-level checks of the translator's stream sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2f_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a new word is only produced while the sequencer is busy
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output word appeared while idle");

    // a word that is not the last of its run keeps the input closed
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of a run");

    // a new write is only taken after the previous run is complete
    a_accept_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid |-> m_tlast)
        else $error("write accepted with a run pending");

endmodule

bind psg_to_fm_register_translator p2f_checker u_p2f_checker (.*);

`default_nettype wire
